FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the button event detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPL(name, ante, cons, msg)
`define ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

FILE: rtl/bce_pkg.sv
// Package: types, codes and reset constants of the button event detector.
`timescale 1ns / 1ps
`default_nettype none

package bce_pkg;

  localparam int BCE_NUM_KEYS = 6;

  localparam int KEY_W  = 3;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int CODE_W = 3;
  localparam int REG_W  = 2;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_SHORT    = 2'd2,
    PH_LONG     = 2'd3
  } phase_t;

  typedef enum logic [CODE_W-1:0] {
    EV_NONE       = 3'd0,
    EV_SINGLE     = 3'd1,
    EV_DOUBLE     = 3'd2,
    EV_LONG_START = 3'd3,
    EV_LONG_END   = 3'd4
  } event_code_t;

  typedef enum logic [REG_W-1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_LONG_PRESS   = 2'd1,
    REG_DOUBLE_CLICK = 2'd2
  } reg_index_t;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = 16'd300;

  // Per-key state word kept in the RAM.
  typedef struct packed {
    phase_t              phase;
    logic [TIME_W-1:0]   press_start;
    logic [TIME_W-1:0]   last_release;
    event_code_t         prev_event;
  } key_entry_t;

  localparam key_entry_t ENTRY_RESET = '{
    phase:        PH_RELEASED,
    press_start:  '0,
    last_release: '0,
    prev_event:   EV_NONE
  };

  // One result waiting in the output queue.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    event_code_t      code;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/bce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/button_click_event_detector.sv
// Top level: per-key debounce, click, double-click and long-press detector.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  in       | in_valid / in_stall   | key_index, key_level, now_ms
//  out      | out_valid / out_stall | event_key, event_code
//  cfg      | cfg_we                | cfg_index, cfg_data (write only)
//
// One item per cycle sustained while in_stall is low; each accepted item gives one
// result (registered RAM read, then update and write-back into the result queue).
// A back-to-back item for the same key takes the just-written state from a
// bypass register, since the RAM read and write land on the same edge.
// Per-key valid bits make unwritten entries read as
// released with zero times. A three-entry result queue lets input continue
// while output stalls; input stalls once the queue plus the update stage hold
// three items.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module button_click_event_detector
  import bce_pkg::*;
#(
  parameter int NUM_KEYS = BCE_NUM_KEYS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KEY_W-1:0]  key_index,
  input  wire logic              key_level,
  input  wire logic [TIME_W-1:0] now_ms,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [KEY_W-1:0]  event_key,
  output logic      [CODE_W-1:0] event_code,
  input  wire logic              cfg_we,
  input  wire logic [REG_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int AW      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int ENTRY_W = $bits(key_entry_t);
  localparam int QDEPTH  = 3;

  // configuration
  logic [CFG_W-1:0] debounce_ms;
  logic [CFG_W-1:0] long_press_ms;
  logic [CFG_W-1:0] double_click_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms     <= DEBOUNCE_RESET;
      long_press_ms   <= LONG_PRESS_RESET;
      double_click_ms <= DOUBLE_CLICK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:     debounce_ms     <= cfg_data;
        REG_LONG_PRESS:   long_press_ms   <= cfg_data;
        REG_DOUBLE_CLICK: double_click_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // input side
  logic                  in_take;
  logic [KEY_W+AW-1:0]   in_key_ext;
  logic [AW-1:0]         in_addr;
  logic                  in_in_range;

  assign in_take     = in_valid && !in_stall;
  assign in_key_ext  = {{AW{1'b0}}, key_index};
  assign in_addr     = in_key_ext[AW-1:0];
  assign in_in_range = in_key_ext < (KEY_W+AW)'(NUM_KEYS);

  // update stage registers
  logic              s1_valid;
  logic              s1_in_range;
  logic [KEY_W-1:0]  s1_key;
  logic [AW-1:0]     s1_addr;
  logic              s1_level;
  logic [TIME_W-1:0] s1_now;
  logic              s1_ent_valid;
  logic              byp_valid;
  key_entry_t        byp_data;

  logic [NUM_KEYS-1:0] valid_bits;
  logic [ENTRY_W-1:0]  ram_rdata;

  key_entry_t  cur;
  key_entry_t  entry_next;
  phase_t      phase_next;
  event_code_t ev;
  logic [TIME_W-1:0] held_ms;
  logic [TIME_W-1:0] gap_ms;
  logic        s1_write;
  logic        is_release_ev;

  bce_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_KEYS)
  ) u_state_ram (
    .clk  (clk),
    .we   (s1_write),
    .waddr(s1_addr),
    .wdata(entry_next),
    .re   (in_take),
    .raddr(in_addr),
    .rdata(ram_rdata)
  );

  assign s1_write = s1_valid && s1_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      byp_valid  <= 1'b0;
      valid_bits <= '0;
    end else begin
      s1_valid  <= in_take;
      // same key written this edge: RAM read returns stale data, so bypass
      byp_valid <= in_take && s1_write && (s1_addr == in_addr);
      if (s1_write) begin
        valid_bits[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_in_range  <= in_in_range;
      s1_key       <= key_index;
      s1_addr      <= in_addr;
      s1_level     <= key_level;
      s1_now       <= now_ms;
      s1_ent_valid <= in_in_range && valid_bits[in_addr];
      byp_data     <= entry_next;
    end
  end

  always_comb begin
    if (byp_valid) begin
      cur = byp_data;
    end else if (s1_ent_valid) begin
      cur = key_entry_t'(ram_rdata);
    end else begin
      cur = ENTRY_RESET;
    end
  end

  assign held_ms = s1_now - cur.press_start;
  assign gap_ms  = cur.press_start - cur.last_release;

  // next phase
  always_comb begin
    phase_next = cur.phase;
    unique case (cur.phase)
      PH_RELEASED: begin
        if (s1_level) phase_next = PH_DEBOUNCE;
      end
      PH_DEBOUNCE: begin
        if (!s1_level) begin
          phase_next = PH_RELEASED;
        end else if (held_ms > {16'd0, debounce_ms}) begin
          phase_next = PH_SHORT;
        end
      end
      PH_SHORT: begin
        // long test comes first, even on a release sample
        if (held_ms > {16'd0, long_press_ms}) begin
          phase_next = PH_LONG;
        end else if (!s1_level) begin
          phase_next = PH_RELEASED;
        end
      end
      PH_LONG: begin
        if (!s1_level) phase_next = PH_RELEASED;
      end
      default: phase_next = PH_RELEASED;
    endcase
  end

  // event and history
  always_comb begin
    ev = EV_NONE;
    unique case (cur.phase)
      PH_SHORT: begin
        if (held_ms > {16'd0, long_press_ms}) begin
          ev = EV_LONG_START;
        end else if (!s1_level) begin
          if (cur.prev_event == EV_SINGLE && gap_ms <= {16'd0, double_click_ms}) begin
            ev = EV_DOUBLE;
          end else begin
            ev = EV_SINGLE;
          end
        end
      end
      PH_LONG: begin
        if (!s1_level) ev = EV_LONG_END;
      end
      PH_RELEASED, PH_DEBOUNCE: ev = EV_NONE;
      default: ev = EV_NONE;
    endcase

    is_release_ev = (ev == EV_SINGLE) || (ev == EV_DOUBLE) || (ev == EV_LONG_END);

    entry_next       = cur;
    entry_next.phase = phase_next;
    if (cur.phase == PH_RELEASED && s1_level) begin
      entry_next.press_start = s1_now;
    end
    if (is_release_ev) begin
      entry_next.last_release = s1_now;
      entry_next.prev_event   = ev;
    end
  end

  // result queue
  result_t          q_mem [QDEPTH];
  logic [1:0]       q_wr;
  logic [1:0]       q_rd;
  logic [1:0]       occ;
  logic             out_take;
  result_t          res;

  assign res.key  = s1_key;
  assign res.code = s1_in_range ? ev : EV_NONE;

  assign out_valid  = (occ != 2'd0);
  assign out_take   = out_valid && !out_stall;
  assign event_key  = q_mem[q_rd].key;
  assign event_code = q_mem[q_rd].code;
  assign in_stall   = ({1'b0, occ} + {2'b00, s1_valid}) >= 3'(QDEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr <= '0;
      q_rd <= '0;
      occ  <= '0;
    end else begin
      if (s1_valid) begin
        q_wr <= (q_wr == 2'(QDEPTH - 1)) ? 2'd0 : q_wr + 2'd1;
      end
      if (out_take) begin
        q_rd <= (q_rd == 2'(QDEPTH - 1)) ? 2'd0 : q_rd + 2'd1;
      end
      occ <= occ + {1'b0, s1_valid} - {1'b0, out_take};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      q_mem[q_wr] <= res;
    end
  end

  `ASSERT_IMPL(a_queue_room, s1_valid, occ <= 2'd2, "result queue would overflow")
  `ASSERT_IMPL(a_bypass_live, byp_valid, s1_valid, "bypass set without a live item")
  `ASSERT_NEXT(a_accept_moves, in_take, s1_valid, "accepted item did not reach update")
  `ASSERT_IMPL(a_range_quiet, s1_valid && !s1_in_range, res.code == EV_NONE,
               "out-of-range key produced an event")

endmodule

`default_nettype wire
